@@ sv/pnss_pkg.sv @@
// Shared constants and the kind priority function of the snap selector.
package pnss_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int KIND_W         = 4;
  localparam int RADIUS_W       = 24;
  localparam int R2_W           = 2 * RADIUS_W;
  localparam int PRIO_W         = 4;

  localparam logic [KIND_W-1:0] KIND_ORIGIN = 4'd1;
  localparam logic [KIND_W-1:0] KIND_GRID   = 4'd8;

  // Origin ranks highest and grid lowest; none and unused codes rank zero.
  function automatic logic [PRIO_W-1:0] kind_priority(input logic [KIND_W-1:0] kind);
    logic [PRIO_W-1:0] prio;
    if (kind >= KIND_ORIGIN && kind <= KIND_GRID) begin
      prio = PRIO_W'(KIND_GRID + KIND_ORIGIN - kind);
    end else begin
      prio = '0;
    end
    return prio;
  endfunction

endpackage

@@ sv/pnss_dist.sv @@
// Distance pipeline: input register, squaring stage and radius test stage.
module pnss_dist #(
  parameter int COORD_BITS = pnss_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pnss_pkg::RADIUS_W-1:0]   cfg_radius,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pnss_pkg::KIND_W-1:0]     cand_kind,
  input  logic signed [COORD_BITS-1:0]    cand_x,
  input  logic signed [COORD_BITS-1:0]    cand_y,
  input  logic signed [COORD_BITS-1:0]    cursor_x,
  input  logic signed [COORD_BITS-1:0]    cursor_y,
  input  logic                            list_end,
  output logic                            c_valid,
  input  logic                            c_ready,
  output logic [pnss_pkg::KIND_W-1:0]     c_kind,
  output logic [COORD_BITS-1:0]           c_x,
  output logic [COORD_BITS-1:0]           c_y,
  output logic [2*COORD_BITS+1:0]         c_dist,
  output logic                            c_hit,
  output logic                            c_last
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int CMP_W  = (DIST_W > pnss_pkg::R2_W) ? DIST_W : pnss_pkg::R2_W;

  // Squared radius, computed once when the register is written.
  logic [pnss_pkg::R2_W-1:0] radius_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq <= '0;
    end else if (cfg_write) begin
      radius_sq <= pnss_pkg::R2_W'(cfg_radius) * pnss_pkg::R2_W'(cfg_radius);
    end
  end

  // Stage A: input register.
  logic                        a_valid;
  logic                        a_ready;
  logic [pnss_pkg::KIND_W-1:0] a_kind;
  logic [COORD_BITS-1:0]       a_cand_x;
  logic [COORD_BITS-1:0]       a_cand_y;
  logic [COORD_BITS-1:0]       a_cur_x;
  logic [COORD_BITS-1:0]       a_cur_y;
  logic                        a_last;

  // Stage B: squared offsets.
  logic                        b_valid;
  logic                        b_ready;
  logic [pnss_pkg::KIND_W-1:0] b_kind;
  logic [COORD_BITS-1:0]       b_x;
  logic [COORD_BITS-1:0]       b_y;
  logic [SQ_W-1:0]             b_sq_x;
  logic [SQ_W-1:0]             b_sq_y;
  logic                        b_last;

  logic [DIFF_W-1:0] diff_x;
  logic [DIFF_W-1:0] diff_y;
  logic [DIFF_W-1:0] abs_x;
  logic [DIFF_W-1:0] abs_y;
  logic [DIST_W-1:0] dist_sum;

  assign a_ready  = !a_valid || b_ready;
  assign b_ready  = !b_valid || !c_valid || c_ready;
  assign in_stall = !a_ready;

  // Offsets are one bit wider than a coordinate, so they never overflow.
  assign diff_x = {a_cand_x[COORD_BITS-1], a_cand_x} - {a_cur_x[COORD_BITS-1], a_cur_x};
  assign diff_y = {a_cand_y[COORD_BITS-1], a_cand_y} - {a_cur_y[COORD_BITS-1], a_cur_y};
  assign abs_x  = diff_x[DIFF_W-1] ? (~diff_x + DIFF_W'(1)) : diff_x;
  assign abs_y  = diff_y[DIFF_W-1] ? (~diff_y + DIFF_W'(1)) : diff_y;

  assign dist_sum = DIST_W'(b_sq_x) + DIST_W'(b_sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (!c_valid || c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_kind   <= cand_kind;
      a_cand_x <= cand_x;
      a_cand_y <= cand_y;
      a_cur_x  <= cursor_x;
      a_cur_y  <= cursor_y;
      a_last   <= list_end;
    end
    if (a_valid && b_ready) begin
      b_kind <= a_kind;
      b_x    <= a_cand_x;
      b_y    <= a_cand_y;
      b_sq_x <= SQ_W'(abs_x) * SQ_W'(abs_x);
      b_sq_y <= SQ_W'(abs_y) * SQ_W'(abs_y);
      b_last <= a_last;
    end
    if (b_valid && (!c_valid || c_ready)) begin
      c_kind <= b_kind;
      c_x    <= b_x;
      c_y    <= b_y;
      c_dist <= dist_sum;
      c_hit  <= CMP_W'(dist_sum) <= CMP_W'(radius_sq);
      c_last <= b_last;
    end
  end

endmodule

@@ sv/pnss_select.sv @@
// Best candidate tracking across a list and the result output register.
module pnss_select #(
  parameter int COORD_BITS = pnss_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            c_valid,
  output logic                            c_ready,
  input  logic [pnss_pkg::KIND_W-1:0]     c_kind,
  input  logic [COORD_BITS-1:0]           c_x,
  input  logic [COORD_BITS-1:0]           c_y,
  input  logic [2*COORD_BITS+1:0]         c_dist,
  input  logic                            c_hit,
  input  logic                            c_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [pnss_pkg::KIND_W-1:0]     best_kind,
  output logic signed [COORD_BITS-1:0]    best_x,
  output logic signed [COORD_BITS-1:0]    best_y
);

  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic                        have_best;
  logic [pnss_pkg::KIND_W-1:0] held_kind;
  logic [COORD_BITS-1:0]       held_x;
  logic [COORD_BITS-1:0]       held_y;
  logic [DIST_W-1:0]           held_dist_sq;

  logic [pnss_pkg::PRIO_W-1:0] prio_cand;
  logic [pnss_pkg::PRIO_W-1:0] prio_held;
  logic                        take;
  logic                        fire;
  logic                        have_next;
  logic [pnss_pkg::KIND_W-1:0] kind_next;
  logic [COORD_BITS-1:0]       x_next;
  logic [COORD_BITS-1:0]       y_next;

  assign prio_cand = pnss_pkg::kind_priority(c_kind);
  assign prio_held = pnss_pkg::kind_priority(held_kind);

  // On equal priority only a strictly nearer point replaces the held one.
  assign take = c_hit && (!have_best || (prio_cand > prio_held) ||
                ((prio_cand == prio_held) && (c_dist < held_dist_sq)));

  assign have_next = have_best || take;
  assign kind_next = take ? c_kind : held_kind;
  assign x_next    = take ? c_x    : held_x;
  assign y_next    = take ? c_y    : held_y;

  // A list end needs room in the output register; other items never wait.
  assign c_ready = !c_last || !out_valid || !out_stall;
  assign fire    = c_valid && c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best    <= 1'b0;
      held_kind    <= '0;
      held_x       <= '0;
      held_y       <= '0;
      held_dist_sq <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (fire) begin
        have_best <= c_last ? 1'b0 : have_next;
        if (take) begin
          held_kind    <= c_kind;
          held_x       <= c_x;
          held_y       <= c_y;
          held_dist_sq <= c_dist;
        end
      end
      if (fire && c_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && c_last) begin
      found     <= have_next;
      best_kind <= have_next ? kind_next : '0;
      best_x    <= have_next ? x_next : '0;
      best_y    <= have_next ? y_next : '0;
    end
  end

endmodule

@@ sv/priority_nearest_snap_select_top.sv @@
// Top level of the priority and nearest snap candidate selector.
// A list's last transaction passes stages A, B and C before its result is registered.
// Throughput: one candidate transaction per cycle, set by the combinational best-candidate
// compare in the selection stage; a list end waits only while a prior result is stalled.
// Reset: synchronous rst clears the pipeline valids, the held candidate and the radius.
// The radius register takes effect on the cycle after it is written.
module priority_nearest_snap_select_top #(
  parameter int COORD_BITS = pnss_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration channel: one register, the snap radius (unsigned Q12.12).
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pnss_pkg::RADIUS_W-1:0]   snap_radius,
  // Candidate channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pnss_pkg::KIND_W-1:0]     cand_kind,
  input  logic signed [COORD_BITS-1:0]    cand_x,
  input  logic signed [COORD_BITS-1:0]    cand_y,
  input  logic signed [COORD_BITS-1:0]    cursor_x,
  input  logic signed [COORD_BITS-1:0]    cursor_y,
  input  logic                            list_end,
  // Result channel: one transaction per list.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [pnss_pkg::KIND_W-1:0]     best_kind,
  output logic signed [COORD_BITS-1:0]    best_x,
  output logic signed [COORD_BITS-1:0]    best_y
);

  localparam int DIST_W = 2 * COORD_BITS + 2;

  // Handoff between the distance pipeline and the selection stage.
  logic                        c_valid;
  logic                        c_ready;
  logic [pnss_pkg::KIND_W-1:0] c_kind;
  logic [COORD_BITS-1:0]       c_x;
  logic [COORD_BITS-1:0]       c_y;
  logic [DIST_W-1:0]           c_dist;
  logic                        c_hit;
  logic                        c_last;

  // The radius register is always writable; the squared radius is
  // computed on the write so the per-candidate path holds no multiply of it.
  assign cfg_ready = 1'b1;

  // The distance pipeline registers the candidate, squares both offsets in
  // one stage, then sums them and tests against the squared radius.
  pnss_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_radius (snap_radius),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cand_kind  (cand_kind),
    .cand_x     (cand_x),
    .cand_y     (cand_y),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .list_end   (list_end),
    .c_valid    (c_valid),
    .c_ready    (c_ready),
    .c_kind     (c_kind),
    .c_x        (c_x),
    .c_y        (c_y),
    .c_dist     (c_dist),
    .c_hit      (c_hit),
    .c_last     (c_last)
  );

  // The selection stage compares each in-range candidate with the held best
  // and, at the end of a list, loads the result register and starts over.
  pnss_select #(
    .COORD_BITS (COORD_BITS)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .c_valid   (c_valid),
    .c_ready   (c_ready),
    .c_kind    (c_kind),
    .c_x       (c_x),
    .c_y       (c_y),
    .c_dist    (c_dist),
    .c_hit     (c_hit),
    .c_last    (c_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .best_kind (best_kind),
    .best_x    (best_x),
    .best_y    (best_y)
  );

  // With the result register empty, nothing downstream can hold the pipeline.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("candidate channel stalled with an empty result register");

  // A list with nothing in range reports all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (best_kind == '0 && best_x == '0 && best_y == '0))
    else $error("empty result carries nonzero fields");

  // A result shows up only after a stage-C list end was taken.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(c_valid && c_ready && c_last))
    else $error("result appeared without a list end");

endmodule

@@ tb/tb_priority_nearest_snap_select_top.sv @@
// Self-checking testbench for the priority and nearest snap candidate selector.
`timescale 1ns / 1ps

module tb_priority_nearest_snap_select_top;

  localparam int CW = pnss_pkg::COORD_BITS_DEF;
  localparam int KW = pnss_pkg::KIND_W;
  localparam int RW = pnss_pkg::RADIUS_W;

  // RESULT_LATENCY is the delay from a list's last transaction to its result; twice that is
  // the quiet time allowed before a radius write and at the end of the run.
  localparam int RESULT_LATENCY = 3;
  localparam int SETTLE_CYCLES  = 2 * RESULT_LATENCY;
  // Longest quiet stretch of a correct run is one sender gap plus one receiver stall
  // plus the pipeline and the settle pause, well under IDLE_LIMIT.
  localparam int IDLE_LIMIT     = 1000;
  localparam int MAX_WAIT       = 15;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 180;

  localparam logic [RW-1:0] UNIT_RADIUS = RW'(4096);  // 1.0 in Q12.12
  localparam logic [RW-1:0] MAX_RADIUS  = '1;
  localparam logic signed [CW-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [CW-1:0] C_MIN = 24'sh800000;

  typedef enum logic [KW-1:0] {
    K_NONE           = 4'd0,
    K_ORIGIN         = 4'd1,
    K_VERTEX         = 4'd2,
    K_ISECT          = 4'd3,
    K_MIDPOINT       = 4'd4,
    K_QUADRANT       = 4'd5,
    K_AXIS           = 4'd6,
    K_ON_CURVE       = 4'd7,
    K_GRID           = 4'd8,
    K_RESERVED_FIRST = 4'd9,
    K_RESERVED_LAST  = 4'd15
  } snap_kind_e;

  typedef struct packed {
    logic [KW-1:0]        kind;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] ux;
    logic signed [CW-1:0] uy;
    logic                 last;
  } cand_t;

  typedef struct packed {
    logic                 found;
    logic [KW-1:0]        kind;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } snap_result_t;

  typedef struct packed {
    cand_t        item;
    logic         typed;
    snap_result_t want;
  } probe_row_t;

  localparam int N_DIRECTED = 21;

  // Directed lists, run with a radius of 1.0. Rows with typed set carry the result that
  // the list must give; the rest are checked against the selection model below.
  probe_row_t directed_rows [N_DIRECTED] = '{
    // A single grid candidate right on the cursor, first list after reset.
    '{'{K_GRID, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, K_GRID, 0, 0}},
    // Nothing within reach: the empty result is all zeros.
    '{'{K_ORIGIN, C_MAX, 0, C_MIN, 0, 1'b1}, 1'b1, '{1'b0, K_NONE, 0, 0}},
    // Origin exactly on the radius outranks the grid before it and the nearer vertex after.
    '{'{K_GRID, 4096, 0, 0, 0, 1'b0}, 1'b0, '0},
    '{'{K_ORIGIN, 0, 4096, 0, 0, 1'b0}, 1'b0, '0},
    '{'{K_VERTEX, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, K_ORIGIN, 0, 4096}},
    // Equal kind and equal distance: the earlier candidate stays.
    '{'{K_AXIS, 4096, 0, 0, 0, 1'b0}, 1'b0, '0},
    '{'{K_AXIS, -4096, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, K_AXIS, 4096, 0}},
    // Equal kind, strictly nearer: the later candidate replaces it.
    '{'{K_MIDPOINT, 4096, 0, 0, 0, 1'b0}, 1'b0, '0},
    '{'{K_MIDPOINT, 100, -100, 0, 0, 1'b1}, 1'b1, '{1'b1, K_MIDPOINT, 100, -100}},
    // One step past the radius is dropped even for the top kind.
    '{'{K_ORIGIN, 4097, 0, 0, 0, 1'b0}, 1'b0, '0},
    '{'{K_ON_CURVE, 10, 10, 0, 0, 1'b1}, 1'b1, '{1'b1, K_ON_CURVE, 10, 10}},
    // None against an unused code: both rank zero, the nearer wins, code reported as is.
    '{'{K_NONE, 20, 0, 0, 0, 1'b0}, 1'b0, '0},
    '{'{K_RESERVED_FIRST, 5, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, K_RESERVED_FIRST, 5, 0}},
    '{'{K_RESERVED_LAST, 0, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, K_RESERVED_LAST, 0, 0}},
    // A near none loses to any real kind in range.
    '{'{K_NONE, 1, 1, 0, 0, 1'b0}, 1'b0, '0},
    '{'{K_QUADRANT, 3000, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, K_QUADRANT, 3000, 0}},
    // The cursor moves inside the list; each candidate uses its own cursor.
    '{'{K_ISECT, 0, 0, 4000, 0, 1'b0}, 1'b0, '0},
    '{'{K_ISECT, 50, 0, 40, 0, 1'b1}, 1'b0, '0},
    // Coordinate extremes.
    '{'{K_GRID, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1}, 1'b1, '{1'b1, K_GRID, C_MAX, C_MAX}},
    '{'{K_VERTEX, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1}, 1'b1, '{1'b1, K_VERTEX, C_MIN, C_MIN}},
    '{'{K_ORIGIN, C_MIN, C_MAX, C_MAX, C_MIN, 1'b1}, 1'b1, '{1'b0, K_NONE, 0, 0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [RW-1:0]        snap_radius = '0;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [KW-1:0]        cand_kind = '0;
  logic signed [CW-1:0] cand_x    = '0;
  logic signed [CW-1:0] cand_y    = '0;
  logic signed [CW-1:0] cursor_x  = '0;
  logic signed [CW-1:0] cursor_y  = '0;
  logic                 list_end  = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 found;
  logic [KW-1:0]        best_kind;
  logic signed [CW-1:0] best_x;
  logic signed [CW-1:0] best_y;

  // Selection model: the radius and the best candidate held so far in the open list.
  logic [RW-1:0]        radius_model = '0;
  logic                 held_valid   = 1'b0;
  logic [KW-1:0]        held_kind    = '0;
  logic signed [CW-1:0] held_x       = '0;
  logic signed [CW-1:0] held_y       = '0;
  longint               held_dsq     = 0;

  snap_result_t pending_snaps [$];
  int           mismatches  = 0;
  int           idle_cycles = 0;
  bit           in_burst    = 1'b0;
  bit           out_burst   = 1'b0;

  always #2 clk = ~clk;

  priority_nearest_snap_select_top #(.COORD_BITS(CW)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .snap_radius (snap_radius),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cand_kind   (cand_kind),
    .cand_x      (cand_x),
    .cand_y      (cand_y),
    .cursor_x    (cursor_x),
    .cursor_y    (cursor_y),
    .list_end    (list_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .best_kind   (best_kind),
    .best_x      (best_x),
    .best_y      (best_y)
  );

  // Origin ranks highest and grid lowest; none and the unused codes rank zero.
  function automatic int kind_rank(input logic [KW-1:0] k);
    if (k >= K_ORIGIN && k <= K_GRID) begin
      return int'(K_GRID) + 1 - int'(k);
    end
    return 0;
  endfunction

  // Folds one accepted candidate into the held best. On the last candidate of a list it
  // hands back the result of the list, clears the held best and returns 1.
  function automatic bit fold_candidate(input cand_t c, output snap_result_t res);
    longint dx;
    longint dy;
    longint dsq;
    longint r2;
    int     cand_rank;
    int     held_rank;
    dx  = longint'(c.cx) - longint'(c.ux);
    dy  = longint'(c.cy) - longint'(c.uy);
    dsq = dx * dx + dy * dy;
    r2  = longint'(radius_model) * longint'(radius_model);
    if (dsq <= r2) begin
      cand_rank = kind_rank(c.kind);
      held_rank = kind_rank(held_kind);
      if (!held_valid || cand_rank > held_rank || (cand_rank == held_rank && dsq < held_dsq)) begin
        held_valid = 1'b1;
        held_kind  = c.kind;
        held_x     = c.cx;
        held_y     = c.cy;
        held_dsq   = dsq;
      end
    end
    res = '0;
    if (!c.last) begin
      return 1'b0;
    end
    if (held_valid) begin
      res = '{1'b1, held_kind, held_x, held_y};
    end
    held_valid = 1'b0;
    return 1'b1;
  endfunction

  // Writes the radius. Called only with no list open and no result in flight.
  task automatic load_radius(input logic [RW-1:0] value);
    cfg_valid   <= 1'b1;
    snap_radius <= value;
    @(negedge clk);
    while (cfg_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    radius_model = value;
    cfg_valid <= 1'b0;
  endtask

  // Presents one candidate after a random gap and holds it until the transaction is taken.
  // A typed row supplies its own expected result; otherwise the model provides it.
  task automatic offer_candidate(input cand_t c, input bit typed, input snap_result_t want);
    int           gap;
    snap_result_t predicted;
    gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cand_kind <= c.kind;
    cand_x    <= c.cx;
    cand_y    <= c.cy;
    cursor_x  <= c.ux;
    cursor_y  <= c.uy;
    list_end  <= c.last;
    // Inputs only move at rising edges, so the stall seen at the falling edge is the one
    // that decides the next edge.
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    if (fold_candidate(c, predicted)) begin
      pending_snaps.insert(pending_snaps.size(), typed ? want : predicted);
    end
  endtask

  // Drops valid and waits until every list has reported and the pipeline has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random lists around a random cursor. Most candidates land near the radius so that
  // the in-range choice is exercised; some repeat the previous distance to force ties,
  // some sit on the radius or one step past it, and the rest are anywhere at all.
  task automatic random_lists(input int item_count);
    int                   sent;
    int                   len;
    int                   i;
    int                   pick;
    longint               span;
    longint               dx;
    longint               dy;
    longint               prev_dx;
    longint               prev_dy;
    logic [KW-1:0]        prev_kind;
    logic signed [CW-1:0] cur_x;
    logic signed [CW-1:0] cur_y;
    bit                   wild;
    cand_t                c;
    sent = 0;
    span = longint'(radius_model) + longint'(radius_model >> 2) + 2;
    while (sent < item_count) begin
      // Short stretches in which one side or both never idle.
      in_burst  = ($urandom_range(0, 5) == 0);
      out_burst = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      if (len > item_count - sent) begin
        len = item_count - sent;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        cur_x = $urandom_range(0, 1) ? C_MAX : C_MIN;
        cur_y = $urandom_range(0, 1) ? C_MAX : C_MIN;
      end else if (pick == 1) begin
        cur_x = CW'(int'($urandom_range(0, 64)) - 32);
        cur_y = CW'(int'($urandom_range(0, 64)) - 32);
      end else begin
        cur_x = CW'($urandom);
        cur_y = CW'($urandom);
      end
      prev_dx   = 0;
      prev_dy   = 0;
      prev_kind = K_NONE;
      for (i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 19) == 0) begin
          cur_x = CW'(longint'(cur_x) + longint'($urandom_range(0, 32)) - 16);
          cur_y = CW'(longint'(cur_y) + longint'($urandom_range(0, 32)) - 16);
        end
        if ($urandom_range(0, 6) == 0) begin
          c.kind = KW'($urandom_range(K_RESERVED_LAST, K_NONE));
        end else begin
          c.kind = KW'($urandom_range(K_GRID, K_NONE));
        end
        wild = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          dx = longint'($urandom_range(0, 32'(2 * span))) - span;
          dy = longint'($urandom_range(0, 32'(2 * span))) - span;
        end else if (pick < 72 && i > 0) begin
          // Same distance and kind as the previous candidate, rotated a quarter turn.
          dx     = -prev_dy;
          dy     = prev_dx;
          c.kind = prev_kind;
        end else if (pick < 86) begin
          // On the radius, or one step outside it, along an axis.
          dx = longint'(radius_model) + longint'($urandom_range(0, 1));
          if ($urandom_range(0, 1)) begin
            dx = -dx;
          end
          dy = 0;
          if ($urandom_range(0, 1)) begin
            dy = dx;
            dx = 0;
          end
        end else begin
          wild = 1'b1;
          c.cx = CW'($urandom);
          c.cy = CW'($urandom);
          dx   = longint'(c.cx) - longint'(cur_x);
          dy   = longint'(c.cy) - longint'(cur_y);
        end
        if (!wild) begin
          c.cx = CW'(longint'(cur_x) + dx);
          c.cy = CW'(longint'(cur_y) + dy);
        end
        c.ux   = cur_x;
        c.uy   = cur_y;
        c.last = (i == len - 1);
        offer_candidate(c, 1'b0, '0);
        prev_dx   = dx;
        prev_dy   = dy;
        prev_kind = c.kind;
      end
      sent += len;
    end
  endtask

  // Result side: stall for a random count of cycles before each result, then take it.
  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
      while (!(out_valid === 1'b1 && !rst)) @(negedge clk);
      @(posedge clk);
    end
  end

  // Checks each result transaction against the oldest pending one, and watches for a
  // hang: too many cycles in a row with no transaction on any channel end the run.
  always @(negedge clk) begin : result_check
    snap_result_t want;
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_snaps.size() == 0) begin
          $display("%0t: result with none pending: found %0d kind %0d x %0d y %0d",
                   $time, found, best_kind, best_x, best_y);
          mismatches++;
        end else begin
          want = pending_snaps.pop_front();
          if (found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, actual %0d", $time, want.found, found);
            mismatches++;
          end
          if (best_kind !== want.kind) begin
            $display("%0t: best_kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, best_kind);
            mismatches++;
          end
          if (best_x !== want.x) begin
            $display("%0t: best_x mismatch, expected %0d, actual %0d", $time, want.x, best_x);
            mismatches++;
          end
          if (best_y !== want.y) begin
            $display("%0t: best_y mismatch, expected %0d, actual %0d", $time, want.y, best_y);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Main sequence: reset, the directed table at a radius of 1.0, then random phases that
  // each start with a new radius. The radius is only rewritten once every list has
  // reported and the pipeline has drained.
  initial begin : stimulus
    int            phase;
    logic [RW-1:0] radius_pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    load_radius(UNIT_RADIUS);
    foreach (directed_rows[i]) begin
      offer_candidate(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    settle();
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: radius_pick = '0;
        1: radius_pick = MAX_RADIUS;
        2: radius_pick = RW'($urandom);
        3, 4: radius_pick = RW'($urandom_range(1, UNIT_RADIUS));
        default: radius_pick = RW'($urandom_range(UNIT_RADIUS + 1, 1 << 20));
      endcase
      load_radius(radius_pick);
      random_lists(PHASE_ITEMS);
      settle();
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
